// File: design/pitch_mode_note_segmenter_assert.svh
// Assertion macros for the note segmenter
`ifndef PITCH_MODE_NOTE_SEGMENTER_ASSERT_SVH
`define PITCH_MODE_NOTE_SEGMENTER_ASSERT_SVH
// antecedent implies consequent in the same cycle
`define PMNS_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("lbl failed");
// antecedent implies consequent in the next cycle
`define PMNS_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("lbl failed");
`endif

// File: design/pmns_pkg.sv
package pmns_pkg;
	localparam int WINDOW_MAX = 16;
	localparam int NOTE_COUNT = 128;
	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam logic [15:0] COUNT_SAT = 16'hFFFF;
	localparam logic signed [23:0] SENTINEL_MEAN = 24'sd1048320;
	localparam logic signed [8:0] NOTE_NONE = -9'sd1;
	localparam logic [4:0] WINDOW_RESET = 5'd10;

	typedef struct packed {
		logic [8:0] note_index;
		logic [23:0] deviation;
	} item_t;

	typedef struct packed {
		logic [8:0] ended_note;
		logic [8:0] new_note;
		logic [15:0] run_length;
		logic [15:0] matched_count;
		logic [23:0] max_neg_dev;
		logic [22:0] max_pos_dev;
		logic [23:0] mean_neg_dev;
		logic [23:0] mean_pos_dev;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_OUTER, ST_INNER, ST_DECIDE, ST_DIV, ST_EMIT
	} state_t;
endpackage

// File: design/pitch_mode_note_segmenter.sv
// Pitch mode note segmenter. Each valid beat on s_axis (note index in range
// 0..127) is written to a ring of window_size slots and a mode vote walks the
// slots with a pair of slot counters, one comparison a cycle. When the winner
// changes, a restoring divider runs twice for the two means (skipped when no
// beat matched, which gives sentinel means) and one event beat leaves on m_axis.
// Out-of-range indices are dropped in the front queue at one beat a cycle while
// it is not full. The front holds two items, so input keeps flowing while the
// vote runs, and the result register lets the next item start while an event
// waits. Register window_size sits at byte address 0; write it only while idle.
module pitch_mode_note_segmenter (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [39:0] s_axis_tdata, // note_index[8:0], deviation[32:9], zero pad
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [151:0] m_axis_tdata, // ended_note, new_note, run_length,
	// matched_count, max_neg_dev, max_pos_dev, mean_neg_dev, mean_pos_dev, pad
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	`include "pitch_mode_note_segmenter_assert.svh"

	logic [4:0] window_q;
	logic q_valid, q_ready, busy;
	pmns_pkg::item_t q_item;
	pmns_pkg::result_t r;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {27'd0, window_q} : 32'd0;

	// hold window size; write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) window_q <= pmns_pkg::WINDOW_RESET;
		else if (psel && penable && pwrite && paddr == 2'd0) window_q <= pwdata[4:0];
	end

	pmns_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_note(s_axis_tdata[8:0]), .in_dev(s_axis_tdata[32:9]),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	pmns_back u_back (
		.clk(clk), .arst_n(arst_n), .window_size(window_q), .q_valid(q_valid),
		.q_ready(q_ready), .q_item(q_item), .res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready), .res(r), .busy(busy)
	);

	assign m_axis_tdata = {7'd0, r.mean_pos_dev, r.mean_neg_dev, r.max_pos_dev,
		r.max_neg_dev, r.matched_count, r.run_length, r.new_note, r.ended_note};

	// an event always names a different note than it ends
	`PMNS_ASSERT_IMP(a_event_changes, m_axis_tvalid, m_axis_tdata[8:0] != m_axis_tdata[17:9])
	// a waiting event holds until taken
	`PMNS_ASSERT_NXT(a_event_holds, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	// when idle with the queue empty, the back end is not busy or holds an event
	`PMNS_ASSERT_IMP(a_take_only_valid, q_ready && !q_valid, !busy || m_axis_tvalid)
endmodule

// File: design/pmns_front.sv
module pmns_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [8:0] in_note,
	input  logic [23:0] in_dev,
	output logic q_valid,
	input  logic q_ready,
	output pmns_pkg::item_t q_item
);
	// two-entry queue of valid items; invalid indices dropped here
	pmns_pkg::item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic ok, push, pop;

	assign ok = !in_note[8] && ({23'd0, in_note} < 32'(pmns_pkg::NOTE_COUNT));
	assign in_ready = cnt_q != 2'd2;
	assign push = in_valid && in_ready && ok;
	assign q_valid = cnt_q != 2'd0;
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{note_index: in_note, deviation: in_dev};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// File: design/pmns_div.sv
module pmns_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [39:0] dividend,
	input  logic [15:0] divisor,
	output logic busy,
	output logic [39:0] quotient
);
	// restoring divider, one quotient bit a cycle
	logic [39:0] q_q;
	logic [16:0] r_q;
	logic [5:0] n_q;
	logic [16:0] trial;

	assign trial = {r_q[15:0], q_q[39]} - {1'b0, divisor};
	assign busy = n_q != 6'd0;
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 6'd0;
		end else if (start) begin
			n_q <= 6'd40;
		end else if (busy) begin
			n_q <= n_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
		end else if (busy) begin
			if (!trial[16]) begin
				r_q <= trial;
				q_q <= {q_q[38:0], 1'b1};
			end else begin
				r_q <= {r_q[15:0], q_q[39]};
				q_q <= {q_q[38:0], 1'b0};
			end
		end
	end
endmodule

// File: design/pmns_back.sv
module pmns_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [4:0] window_size,
	input  logic q_valid,
	output logic q_ready,
	input  pmns_pkg::item_t q_item,
	output logic res_valid,
	input  logic res_ready,
	output pmns_pkg::result_t res,
	output logic busy
);
	localparam int SW = pmns_pkg::SLOT_W;
	localparam int CW = pmns_pkg::CNT_W;

	pmns_pkg::state_t st_q, st_d;
	logic [8:0] ring_q [pmns_pkg::WINDOW_MAX];
	logic [pmns_pkg::WINDOW_MAX-1:0] rvalid_q;
	logic [SW-1:0] wslot_q;
	logic [CW-1:0] size;
	logic [SW-1:0] i_q, j_q;
	logic [CW-1:0] c_q, best_c_q;
	logic [8:0] best_q;
	pmns_pkg::item_t it_q;
	logic [8:0] held_q;
	logic [15:0] run_q, match_q;
	logic signed [23:0] pmax_q, nmax_q;
	logic signed [39:0] psum_q, nsum_q;
	logic div_phase_q; // 0: neg sum, 1: pos sum
	logic signed [23:0] mneg_q;
	logic res_v_q;
	pmns_pkg::result_t res_q;
	logic div_start, div_busy;
	logic [39:0] div_in, div_out;
	logic [39:0] nmag;
	logic [CW-1:0] c_inc;
	logic last_j, last_i, win_diff;
	logic signed [23:0] dev_s;
	logic signed [39:0] q_signed;

	// v mod sz for a small v, by shifted compare and subtract
	function automatic logic [SW-1:0] wrap_slot(input logic [CW-1:0] v, input logic [CW-1:0] sz);
		logic [CW+SW-1:0] r;
		logic [CW+SW-1:0] d;
		r = (CW+SW)'(v);
		for (int k = SW; k >= 0; k--) begin
			d = (CW+SW)'(sz) << k;
			if (r >= d) r = r - d;
		end
		return r[SW-1:0];
	endfunction

	always_comb begin
		if (window_size == 5'd0) size = CW'(1);
		else if (32'(window_size) > pmns_pkg::WINDOW_MAX) size = CW'(pmns_pkg::WINDOW_MAX);
		else size = CW'(window_size);
	end

	assign c_inc = (rvalid_q[j_q] && ring_q[j_q] == ring_q[i_q]) ? c_q + CW'(1) : c_q;
	assign last_j = j_q == i_q;
	assign last_i = {1'b0, i_q} == size - CW'(1);
	assign win_diff = best_q != held_q;
	assign dev_s = it_q.deviation;
	assign nmag = -nsum_q;
	assign div_in = (st_q == pmns_pkg::ST_DECIDE) ? nmag : psum_q;
	assign q_signed = div_out;

	pmns_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_in),
		.divisor(match_q), .busy(div_busy), .quotient(div_out)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			pmns_pkg::ST_IDLE: if (q_valid) st_d = pmns_pkg::ST_OUTER;
			pmns_pkg::ST_OUTER: st_d = rvalid_q[i_q] ? pmns_pkg::ST_INNER
				: (last_i ? pmns_pkg::ST_DECIDE : pmns_pkg::ST_OUTER);
			pmns_pkg::ST_INNER: if (last_j) st_d = last_i ? pmns_pkg::ST_DECIDE
				: pmns_pkg::ST_OUTER;
			pmns_pkg::ST_DECIDE: if (!win_diff) st_d = pmns_pkg::ST_IDLE;
				else if (match_q == 16'd0) st_d = pmns_pkg::ST_EMIT;
				else if (!res_v_q) st_d = pmns_pkg::ST_DIV;
			pmns_pkg::ST_DIV: if (!div_busy && div_phase_q) st_d = pmns_pkg::ST_EMIT;
			pmns_pkg::ST_EMIT: if (!res_v_q) st_d = pmns_pkg::ST_IDLE;
			default: st_d = pmns_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = st_q == pmns_pkg::ST_IDLE;
		div_start = (st_q == pmns_pkg::ST_DECIDE && st_d == pmns_pkg::ST_DIV)
			|| (st_q == pmns_pkg::ST_DIV && !div_busy && !div_phase_q);
		busy = st_q != pmns_pkg::ST_IDLE || res_v_q;
	end

	assign res_valid = res_v_q;
	assign res = res_q;

	always_ff @(posedge clk) begin
		if (st_q == pmns_pkg::ST_IDLE && q_valid) begin
			ring_q[wslot_q] <= q_item.note_index;
			it_q <= q_item;
		end
		if (st_q == pmns_pkg::ST_DIV && !div_busy && !div_phase_q) begin
			mneg_q <= -(div_out[23:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pmns_pkg::ST_IDLE;
			rvalid_q <= '0;
			wslot_q <= '0;
			held_q <= pmns_pkg::NOTE_NONE;
			run_q <= '0; match_q <= '0;
			pmax_q <= '0; nmax_q <= '0; psum_q <= '0; nsum_q <= '0;
			i_q <= '0; j_q <= '0; c_q <= '0; best_c_q <= '0;
			best_q <= pmns_pkg::NOTE_NONE;
			div_phase_q <= 1'b0;
			res_v_q <= 1'b0;
			res_q <= '0;
		end else begin
			st_q <= st_d;
			if (res_v_q && res_ready) res_v_q <= 1'b0;
			case (st_q)
				pmns_pkg::ST_IDLE: if (q_valid) begin
					rvalid_q[wslot_q] <= 1'b1;
					wslot_q <= wrap_slot({1'b0, wslot_q} + CW'(1), size);
					i_q <= '0; j_q <= '0; c_q <= '0; best_c_q <= '0;
					best_q <= pmns_pkg::NOTE_NONE;
				end
				pmns_pkg::ST_OUTER: begin
					j_q <= '0; c_q <= '0;
					if (!rvalid_q[i_q] && !last_i) i_q <= i_q + SW'(1);
				end
				pmns_pkg::ST_INNER: begin
					c_q <= c_inc;
					j_q <= j_q + SW'(1);
					if (last_j) begin
						if (c_inc > best_c_q) begin
							best_c_q <= c_inc;
							best_q <= ring_q[i_q];
						end
						if (!last_i) i_q <= i_q + SW'(1);
					end
				end
				pmns_pkg::ST_DECIDE: if (!win_diff) begin
					if (run_q != pmns_pkg::COUNT_SAT) run_q <= run_q + 16'd1;
					if (it_q.note_index == best_q) begin
						if (dev_s > 24'sd0) begin
							if (dev_s > pmax_q) pmax_q <= dev_s;
							if (match_q != pmns_pkg::COUNT_SAT) psum_q <= psum_q + 40'(dev_s);
						end else begin
							if (dev_s < nmax_q) nmax_q <= dev_s;
							if (match_q != pmns_pkg::COUNT_SAT) nsum_q <= nsum_q + 40'(dev_s);
						end
						if (match_q != pmns_pkg::COUNT_SAT) match_q <= match_q + 16'd1;
					end
				end else begin
					div_phase_q <= 1'b0;
				end
				pmns_pkg::ST_DIV: if (!div_busy && !div_phase_q) div_phase_q <= 1'b1;
				pmns_pkg::ST_EMIT: if (!res_v_q) begin
					res_v_q <= 1'b1;
					res_q.ended_note <= held_q;
					res_q.new_note <= best_q;
					res_q.run_length <= run_q;
					res_q.matched_count <= match_q;
					res_q.max_neg_dev <= nmax_q;
					res_q.max_pos_dev <= pmax_q[22:0];
					res_q.mean_neg_dev <= (match_q == 16'd0) ? -pmns_pkg::SENTINEL_MEAN : mneg_q;
					res_q.mean_pos_dev <= (match_q == 16'd0) ? pmns_pkg::SENTINEL_MEAN
						: q_signed[23:0];
					held_q <= best_q;
					run_q <= '0; match_q <= '0;
					pmax_q <= '0; nmax_q <= '0; psum_q <= '0; nsum_q <= '0;
				end
				default: ;
			endcase
		end
	end
endmodule

// File: tb/sv/pitch_mode_note_segmenter_test.sv
`timescale 1ns / 100ps

module pitch_mode_note_segmenter_test;
	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata; // note_index[8:0], deviation[32:9], zero pad
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [151:0] m_axis_tdata; // ended_note[8:0], new_note[17:9], run_length[33:18],
	// matched_count[49:34], max_neg_dev[73:50], max_pos_dev[96:74],
	// mean_neg_dev[120:97], mean_pos_dev[144:121], zero pad
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	localparam logic [1:0] ADDR_WINDOW_SIZE = 2'd0;
	// three items in flight, each a worst vote plus both divides, with margin
	localparam int SETTLE_CYCLES = 1000;

	pitch_mode_note_segmenter uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Segmenter shadow state, advanced once per accepted beat
	logic [4:0] win_reg;
	int ring_note[pmns_pkg::WINDOW_MAX];
	bit ring_full[pmns_pkg::WINDOW_MAX];
	int next_slot;
	int cur_note;
	int run_cnt;
	int match_cnt;
	longint pos_peak;
	longint neg_peak;
	longint pos_total;
	longint neg_total;

	pmns_pkg::item_t pending_items[$];
	pmns_pkg::result_t note_events[$];
	int fail_count = 0;
	int event_count = 0;
	int beat_count = 0;
	bit steady_send = 1'b0; // no gaps while set
	bit hold_request = 1'b0;

	function automatic longint avg_dev(longint sum, int cnt, longint none);
		if (cnt == 0)
			return none;
		return sum / cnt; // truncates toward zero
	endfunction

	function automatic void clear_run();
		run_cnt = 0;
		match_cnt = 0;
		pos_peak = 0;
		neg_peak = 0;
		pos_total = 0;
		neg_total = 0;
	endfunction

	function automatic void segment_beat(pmns_pkg::item_t it);
		int idx;
		longint dev;
		int size;
		int winner;
		int top;
		int cnt;
		pmns_pkg::result_t ev;
		idx = int'($signed(it.note_index));
		dev = longint'($signed(it.deviation));
		size = (win_reg == 0) ? 1 : (win_reg > pmns_pkg::WINDOW_MAX) ? pmns_pkg::WINDOW_MAX
			: int'(win_reg);
		if (idx < 0 || idx >= pmns_pkg::NOTE_COUNT)
			return;
		if (next_slot >= pmns_pkg::WINDOW_MAX)
			next_slot = 0;
		ring_note[next_slot] = idx;
		ring_full[next_slot] = 1'b1;
		next_slot = (next_slot + 1) % size;
		// first note to reach a strictly higher count wins
		winner = -1;
		top = 0;
		for (int i = 0; i < size; i++) begin
			if (ring_full[i]) begin
				cnt = 0;
				for (int j = 0; j <= i; j++)
					if (ring_full[j] && ring_note[j] == ring_note[i])
						cnt++;
				if (cnt > top) begin
					top = cnt;
					winner = ring_note[i];
				end
			end
		end
		if (winner != cur_note) begin
			ev.ended_note = cur_note[8:0];
			ev.new_note = winner[8:0];
			ev.run_length = run_cnt[15:0];
			ev.matched_count = match_cnt[15:0];
			ev.max_neg_dev = neg_peak[23:0];
			ev.max_pos_dev = pos_peak[22:0];
			ev.mean_neg_dev = 24'(avg_dev(neg_total, match_cnt,
				-longint'(pmns_pkg::SENTINEL_MEAN)));
			ev.mean_pos_dev = 24'(avg_dev(pos_total, match_cnt,
				longint'(pmns_pkg::SENTINEL_MEAN)));
			note_events = {note_events, ev};
			cur_note = winner;
			clear_run();
			return;
		end
		if (run_cnt < 65535)
			run_cnt++;
		if (idx == winner) begin
			if (dev > 0) begin
				if (dev > pos_peak)
					pos_peak = dev;
				if (match_cnt < 65535)
					pos_total += dev;
			end else begin
				if (dev < neg_peak)
					neg_peak = dev;
				if (match_cnt < 65535)
					neg_total += dev;
			end
			if (match_cnt < 65535)
				match_cnt++;
		end
	endfunction

	// Sender: bursts of random length, random gaps between them
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				segment_beat(pending_items.pop_front());
				beat_count++;
			end
			if (gap_left > 0 && !steady_send) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {7'd0, pending_items[0].deviation, pending_items[0].note_index};
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					// a random quarter of bursts run back to back
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v,
				act_v);
			fail_count++;
		end
	endtask

	// Receiver: stalls on its own pattern, plus one long hold-off on request
	int hold_cnt = 0;
	bit hold_done = 1'b0;
	int stall_mode = 0;
	int mode_left = 0;

	always @(posedge clk or negedge arst_n) begin
		pmns_pkg::result_t exp_ev;
		pmns_pkg::result_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.ended_note = m_axis_tdata[8:0];
				got.new_note = m_axis_tdata[17:9];
				got.run_length = m_axis_tdata[33:18];
				got.matched_count = m_axis_tdata[49:34];
				got.max_neg_dev = m_axis_tdata[73:50];
				got.max_pos_dev = m_axis_tdata[96:74];
				got.mean_neg_dev = m_axis_tdata[120:97];
				got.mean_pos_dev = m_axis_tdata[144:121];
				event_count++;
				if (note_events.size() == 0) begin
					$display("%0t: unexpected event beat, expected none, actual %h", $realtime,
						got);
					fail_count++;
				end else begin
					exp_ev = note_events.pop_front();
					check_field("ended_note", $signed(exp_ev.ended_note),
						$signed(got.ended_note));
					check_field("new_note", $signed(exp_ev.new_note), $signed(got.new_note));
					check_field("run_length", exp_ev.run_length, got.run_length);
					check_field("matched_count", exp_ev.matched_count, got.matched_count);
					check_field("max_neg_dev", $signed(exp_ev.max_neg_dev),
						$signed(got.max_neg_dev));
					check_field("max_pos_dev", exp_ev.max_pos_dev, got.max_pos_dev);
					check_field("mean_neg_dev", $signed(exp_ev.mean_neg_dev),
						$signed(got.mean_neg_dev));
					check_field("mean_pos_dev", $signed(exp_ev.mean_pos_dev),
						$signed(got.mean_pos_dev));
				end
			end
			if (hold_request && !hold_done) begin
				// hold off long enough for the front queue to fill
				if (hold_cnt < 3000) begin
					hold_cnt <= hold_cnt + 1;
					m_axis_tready <= 1'b0;
				end else begin
					hold_done <= 1'b1;
					m_axis_tready <= 1'b1;
				end
			end else begin
				if (mode_left == 0) begin
					stall_mode <= $urandom_range(0, 2);
					mode_left <= $urandom_range(20, 300);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (stall_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic write_window(int value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_WINDOW_SIZE;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		win_reg = value[4:0];
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || s_axis_tvalid || note_events.size() > 0)
			@(posedge clk);
		// an ignored or silent beat may still be in the vote
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void add_item(int idx, int dev);
		pmns_pkg::item_t it;
		it.note_index = idx[8:0];
		it.deviation = dev[23:0];
		pending_items = {pending_items, it};
	endfunction

	function automatic int rand_dev();
		case ($urandom_range(0, 7))
			0: return 8388607;
			1: return -8388608;
			2: return 0;
			3: return int'($urandom_range(0, 2000)) - 1000;
			default: return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
		endcase
	endfunction

	// Well-formed runs of a few pool notes, with stray and invalid beats
	function automatic void add_random_run(int count);
		int pool[3];
		int note;
		int run;
		for (int k = 0; k < 3; k++)
			pool[k] = $urandom_range(0, pmns_pkg::NOTE_COUNT - 1);
		while (count > 0) begin
			note = pool[$urandom_range(0, 2)];
			run = $urandom_range(1, 24);
			for (int k = 0; k < run && count > 0; k++) begin
				case ($urandom_range(0, 19))
					0: add_item(-1, rand_dev());
					1: add_item($urandom_range(pmns_pkg::NOTE_COUNT, 255), rand_dev());
					2, 3: add_item($urandom_range(0, pmns_pkg::NOTE_COUNT - 1), rand_dev());
					default: begin
						add_item(note, rand_dev());
						count--;
					end
				endcase
			end
		end
	endfunction

	initial begin
		int window_plan[8];
		window_plan = '{1, 16, 0, 31, 5, 3, 7, 16};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		win_reg = pmns_pkg::WINDOW_RESET;
		for (int i = 0; i < pmns_pkg::WINDOW_MAX; i++) begin
			ring_note[i] = -1;
			ring_full[i] = 1'b0;
		end
		next_slot = 0;
		cur_note = -1;
		clear_run();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: invalid indices, index extremes, deviation extremes and zero
		add_item(-1, 5);
		add_item(pmns_pkg::NOTE_COUNT, 5);
		add_item(255, -5);
		add_item(0, 0);
		add_item(0, 8388607);
		add_item(0, -8388608);
		add_item(0, -1);
		add_item(0, 1);
		add_item(127, 300);
		add_item(127, -300);
		add_item(127, 8388607);
		add_item(127, -8388608);
		add_item(127, 0);
		add_item(127, 77);
		add_item(5, 3);
		add_item(127, -9);
		wait_idle();
		write_window(1);
		add_item(127, 0);
		add_item(64, 8388607);
		add_item(64, -8388608);
		add_item(1, 100);
		wait_idle();

		// Random phases across window settings; one long receiver hold-off
		for (int p = 0; p < 8; p++) begin
			write_window(window_plan[p]);
			add_random_run(150);
			if (p == 2)
				hold_request = 1'b1;
			wait_idle();
		end

		$display("Drove %0d beats and checked %0d note events.", beat_count, event_count);
		$display("Covered window sizes 0 to 31, invalid indices, deviation extremes and a long output hold-off.");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#40ms;
		$display("simulation failed");
		$finish;
	end
endmodule
